@@ rtl/imhnf_pkg.sv @@
// ----------------------------------------------------------------------------
// imhnf_pkg: shared types and constants for the Hermite normal form block
// Status codes, sequencer states and divider request types.
// ----------------------------------------------------------------------------
package imhnf_pkg;

  localparam int unsigned ENTRY_WIDTH_DEF   = 24;
  localparam int unsigned MAX_DIMENSION_DEF = 3;
  localparam int unsigned STATUS_WIDTH      = 2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_SINGULAR = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PIV_SCAN,
    S_PIV_SWAP,
    S_PIV_NEG,
    S_EUC_DIV,
    S_EUC_WAIT,
    S_EUC_SUB,
    S_FIN_DIV,
    S_FIN_WAIT,
    S_FIN_SUB,
    S_LEAD,
    S_RED_DIV,
    S_RED_WAIT,
    S_RED_SUB,
    S_MUL,
    S_DONE
  } seq_state_e;

  // Floor-division request handed to the shared divider.
  typedef struct packed {
    logic        start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
  } div_stat_t;

endpackage

@@ rtl/imhnf_if.sv @@
// ----------------------------------------------------------------------------
// imhnf_if: valid/ready channel
// Carries one request payload of configurable type.
// ----------------------------------------------------------------------------
interface imhnf_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/imhnf_div.sv @@
// ----------------------------------------------------------------------------
// imhnf_div: iterative floor divider
// Restoring division, one quotient bit a cycle; floor correction at the end.
// Denominator is always positive.
// ----------------------------------------------------------------------------
module imhnf_div #(
  parameter int unsigned W = 26
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  imhnf_pkg::div_req_t          req_i,
  output imhnf_pkg::div_stat_t         stat_o,
  output logic signed [W-1:0]          quot_o,
  output logic                         exact_o
);
  import imhnf_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]   num_q, num_d;
  logic [W-1:0]   den_q, den_d;
  logic [W:0]     rem_q, rem_d;
  logic [W-1:0]   quo_q, quo_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           neg_q, neg_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [W:0]     trial;
  logic [W-1:0]   mag;

  assign mag   = req_i.num[W-1] ? W'(-req_i.num[W-1:0]) : req_i.num[W-1:0];
  assign trial = {rem_q[W-1:0], num_q[W-1]} - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = mag;
      den_d  = req_i.den[W-1:0];
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CW'(W);
      neg_d  = req_i.num[W-1];
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      if (!trial[W]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-1:0], num_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // floor: negative with remainder -> -(q+1)
  always_comb begin
    exact_o = (rem_q == '0);
    if (neg_q) quot_o = exact_o ? -$signed(quo_q) : -$signed(quo_q) - W'(1);
    else       quot_o = $signed(quo_q);
  end

  assign stat_o.done = done_q;
  assign stat_o.busy = busy_q;
endmodule

@@ rtl/imhnf_seq.sv @@
// ----------------------------------------------------------------------------
// imhnf_seq: reduction sequencer
// Holds the matrix, steps the column reduction and drives the shared divider
// and the single multiply-subtract lane.
// ----------------------------------------------------------------------------
module imhnf_seq #(
  parameter int unsigned ENTRY_WIDTH   = 24,
  parameter int unsigned MAX_DIMENSION = 3
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [1:0]                                 dim_i,
  input  logic signed [ENTRY_WIDTH-1:0]              mat_i [9],
  output logic                                       done_o,
  output logic signed [ENTRY_WIDTH-1:0]              mat_o [9],
  output logic [imhnf_pkg::STATUS_WIDTH-1:0]         status_o
);
  import imhnf_pkg::*;

  localparam int unsigned E  = ENTRY_WIDTH;
  localparam int unsigned DW = E + 2;   // divider width: magnitude and sign room

  seq_state_e state_q, state_d;
  logic signed [E-1:0] m_q [3][3];
  logic signed [E-1:0] m_d [3][3];
  logic [1:0] n_q, n_d, c_q, c_d, r_q, r_d, k_q, k_d, best_q, best_d;
  logic [1:0] ret_q, ret_d;             // state code after a row subtract
  logic       found_q, found_d;
  logic [E:0] pm_q, pm_d;               // pivot magnitude, up to 2^(E-1)
  logic signed [DW-1:0] q_q, q_d;
  logic signed [2*E+DW-1:0] prod_q, prod_d;
  logic [STATUS_WIDTH-1:0] st_q, st_d;
  logic [1:0] sr_q, sr_d, sp_q, sp_d, last_q, last_d; // row-op rows, last column
  logic       done_q, done_d;

  div_req_t  dreq;
  div_stat_t dstat;
  logic signed [DW-1:0] dquo;
  logic dexact;

  localparam logic [1:0] RET_EUC = 2'd0;
  localparam logic [1:0] RET_FIN = 2'd1;
  localparam logic [1:0] RET_RED = 2'd2;

  imhnf_div #(.W(DW)) u_div (
    .clk_i, .rst_ni, .req_i(dreq), .stat_o(dstat), .quot_o(dquo), .exact_o(dexact)
  );

  function automatic logic in_rng(input logic signed [2*E+DW:0] v);
    logic signed [2*E+DW:0] hi, lo;
    hi = (2*E+DW+1)'((64'sd1 <<< (E-1)) - 1);
    lo = -(2*E+DW+1)'(64'sd1 <<< (E-1));
    return (v <= hi) && (v >= lo);
  endfunction

  logic [E:0] absv;
  logic signed [E:0] negv;
  logic signed [2*E+DW:0] diff;

  always_comb begin
    state_d = state_q;
    m_d = m_q; n_d = n_q; c_d = c_q; r_d = r_q; k_d = k_q; best_d = best_q;
    ret_d = ret_q; found_d = found_q; pm_d = pm_q;
    q_d = q_q; prod_d = prod_q; st_d = st_q; sr_d = sr_q; sp_d = sp_q;
    last_d = last_q; done_d = 1'b0;
    dreq = '0;
    absv = '0; negv = '0; diff = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d = (dim_i < 2'd2) ? 2'd2 :
                (dim_i > 2'(MAX_DIMENSION)) ? 2'(MAX_DIMENSION) : dim_i;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              m_d[i][j] = (i < n_d && j < n_d) ? mat_i[i*3+j] : '0;
          c_d = n_d - 2'd1; r_d = '0; found_d = 1'b0; st_d = ST_OK;
          state_d = S_PIV_SCAN;
        end
      end
      // Smallest nonzero magnitude in rows 0..c of column c, one row a cycle.
      S_PIV_SCAN: begin
        absv = m_q[r_q][c_q][E-1] ? (E+1)'(-{m_q[r_q][c_q][E-1], m_q[r_q][c_q]})
                                  : (E+1)'({1'b0, m_q[r_q][c_q]});
        if (absv != '0 && (!found_q || absv < pm_q)) begin
          found_d = 1'b1; best_d = r_q; pm_d = absv;
        end
        if (r_q == c_q) begin
          if (!(found_q || absv != '0)) begin
            st_d = ST_SINGULAR; state_d = S_DONE;
          end else state_d = S_PIV_SWAP;
        end else r_d = r_q + 2'd1;
      end
      S_PIV_SWAP: begin
        for (int j = 0; j < 3; j++) begin
          m_d[best_q][j] = m_q[c_q][j];
          m_d[c_q][j]    = m_q[best_q][j];
        end
        k_d = '0;
        state_d = m_q[best_q][c_q][E-1] ? S_PIV_NEG : S_EUC_DIV;
        r_d = '0;
      end
      S_PIV_NEG: begin
        negv = -(E+1)'(m_q[c_q][k_q]);
        if (!in_rng((2*E+DW+1)'(negv))) begin
          st_d = ST_OVERFLOW; state_d = S_DONE;
        end else begin
          m_d[c_q][k_q] = negv[E-1:0];
          if (k_q == c_q) begin state_d = S_EUC_DIV; r_d = '0; end
          else k_d = k_q + 2'd1;
        end
      end
      // Euclidean sweep: find first row above the pivot with nonzero remainder.
      S_EUC_DIV: begin
        if (r_q == c_q) begin
          r_d = '0; state_d = S_FIN_DIV;
        end else begin
          dreq.start = 1'b1;
          dreq.num = 64'(m_q[r_q][c_q]);
          dreq.den = 64'(pm_q);
          state_d = S_EUC_WAIT;
        end
      end
      S_EUC_WAIT: begin
        if (dstat.done) begin
          if (dexact) begin
            r_d = r_q + 2'd1; state_d = S_EUC_DIV;
          end else begin
            q_d = dquo; sr_d = r_q; sp_d = c_q; last_d = c_q; k_d = '0;
            ret_d = RET_EUC; state_d = S_MUL;
          end
        end
      end
      S_FIN_DIV: begin
        if (r_q == c_q) begin
          if (c_q == 2'd1) state_d = S_LEAD;
          else begin
            c_d = c_q - 2'd1; r_d = '0; found_d = 1'b0; state_d = S_PIV_SCAN;
          end
        end else begin
          dreq.start = 1'b1;
          dreq.num = 64'(m_q[r_q][c_q]);
          dreq.den = 64'(pm_q);
          state_d = S_FIN_WAIT;
        end
      end
      S_FIN_WAIT: begin
        if (dstat.done) begin
          q_d = dquo; sr_d = r_q; sp_d = c_q; last_d = c_q; k_d = '0;
          ret_d = RET_FIN; state_d = S_MUL;
        end
      end
      S_LEAD: begin
        if (m_q[0][0] == '0) begin
          st_d = ST_SINGULAR; state_d = S_DONE;
        end else if (m_q[0][0][E-1]) begin
          negv = -(E+1)'(m_q[0][0]);
          if (!in_rng((2*E+DW+1)'(negv))) begin
            st_d = ST_OVERFLOW; state_d = S_DONE;
          end else m_d[0][0] = negv[E-1:0];
        end
        if (m_q[0][0] != '0 && !(m_q[0][0][E-1] &&
            !in_rng((2*E+DW+1)'(-(E+1)'(m_q[0][0]))))) begin
          c_d = n_q - 2'd2; r_d = n_q - 2'd1; state_d = S_RED_DIV;
        end
      end
      // Reduce row r (below diagonal) in column c modulo the diagonal.
      S_RED_DIV: begin
        dreq.start = 1'b1;
        dreq.num = 64'(m_q[r_q][c_q]);
        dreq.den = 64'(m_q[c_q][c_q]);
        state_d = S_RED_WAIT;
      end
      S_RED_WAIT: begin
        if (dstat.done) begin
          q_d = dquo; sr_d = r_q; sp_d = c_q; last_d = c_q; k_d = '0;
          ret_d = RET_RED; state_d = S_MUL;
        end
      end
      // Multiply-subtract lane: for each column the product is registered first (S_MUL), then subtracted (S_EUC_SUB).
      S_MUL: begin
        prod_d = (2*E+DW)'(m_q[sp_q][k_q] * q_q);
        state_d = S_EUC_SUB;
      end
      S_EUC_SUB: begin
        diff = (2*E+DW+1)'(m_q[sr_q][k_q]) - (2*E+DW+1)'(prod_q);
        if (!in_rng(diff)) begin
          st_d = ST_OVERFLOW; state_d = S_DONE;
        end else begin
          m_d[sr_q][k_q] = diff[E-1:0];
          if (k_q != last_q) begin
            k_d = k_q + 2'd1; state_d = S_MUL;
          end else begin
            state_d = S_FIN_SUB;
          end
        end
      end
      // Row op finished: continue the loop that asked for it.
      S_FIN_SUB: begin
        case (ret_q)
          RET_EUC: begin
            for (int j = 0; j < 3; j++) begin
              m_d[sr_q][j] = m_q[c_q][j];
              m_d[c_q][j]  = m_q[sr_q][j];
            end
            pm_d = (E+1)'($unsigned({1'b0, m_q[sr_q][c_q]}));
            r_d = '0; state_d = S_EUC_DIV;
          end
          RET_FIN: begin
            r_d = r_q + 2'd1; state_d = S_FIN_DIV;
          end
          default: begin
            if (r_q != n_q - 2'd1) begin
              r_d = r_q + 2'd1; state_d = S_RED_DIV;
            end else if (c_q == 2'd0) begin
              state_d = S_DONE;
            end else begin
              c_d = c_q - 2'd1; r_d = c_q; state_d = S_RED_DIV;
            end
          end
        endcase
      end
      S_RED_SUB: state_d = S_DONE;
      S_DONE: begin
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; n_q <= n_d; c_q <= c_d; r_q <= r_d; k_q <= k_d; best_q <= best_d;
    ret_q <= ret_d; found_q <= found_d; pm_q <= pm_d;
    q_q <= q_d; prod_q <= prod_d; st_q <= st_d; sr_q <= sr_d; sp_q <= sp_d;
    last_q <= last_d;
  end

  assign done_o   = done_q;
  assign status_o = st_q;
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        mat_o[i*3+j] = (st_q == ST_OK) ? m_q[i][j] : '0;
  end
endmodule

@@ rtl/integer_matrix_hermite_normal_form.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_hermite_normal_form: lower-triangular HNF of a 2x2/3x3 matrix
// Sequencer plus one shared divider and one multiply-subtract lane.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | dimension, in_r0c0 .. in_r2c2
//  out_ch  | out | out_r0c0 .. out_r2c2, status
//
//  Each matrix goes through pivot scan, swap, sign and hand-off, floor
//  divisions, and row operations that update their entries in turn. The
//  number of Euclidean steps depends on the data; the bit-serial divider
//  sets the pace.
//  Reset clears the sequencer state, the divider control and the output valid; nothing else.
//  in_ch.ready is high only while idle; a waiting result holds until taken.
module integer_matrix_hermite_normal_form #(
  parameter int unsigned ENTRY_WIDTH   = imhnf_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned MAX_DIMENSION = imhnf_pkg::MAX_DIMENSION_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  imhnf_if.sink   in_ch,
  imhnf_if.source out_ch
);
  import imhnf_pkg::*;

  typedef enum logic [1:0] { T_IDLE, T_BUSY, T_OUT } top_state_e;
  top_state_e tst_q, tst_d;

  logic seq_done;
  logic signed [ENTRY_WIDTH-1:0] mat_in [9];
  logic signed [ENTRY_WIDTH-1:0] mat_out [9];
  logic [STATUS_WIDTH-1:0] st;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (tst_q == T_IDLE);

  assign mat_in[0] = in_ch.data.in_r0c0;
  assign mat_in[1] = in_ch.data.in_r0c1;
  assign mat_in[2] = in_ch.data.in_r0c2;
  assign mat_in[3] = in_ch.data.in_r1c0;
  assign mat_in[4] = in_ch.data.in_r1c1;
  assign mat_in[5] = in_ch.data.in_r1c2;
  assign mat_in[6] = in_ch.data.in_r2c0;
  assign mat_in[7] = in_ch.data.in_r2c1;
  assign mat_in[8] = in_ch.data.in_r2c2;

  imhnf_seq #(.ENTRY_WIDTH(ENTRY_WIDTH), .MAX_DIMENSION(MAX_DIMENSION)) u_seq (
    .clk_i, .rst_ni, .start_i(accept), .dim_i(in_ch.data.dimension),
    .mat_i(mat_in), .done_o(seq_done), .mat_o(mat_out), .status_o(st)
  );

  // Hold the result in the sequencer registers until the sink takes it.
  always_comb begin
    tst_d = tst_q;
    unique case (tst_q)
      T_IDLE: if (accept) tst_d = T_BUSY;
      T_BUSY: if (seq_done) tst_d = T_OUT;
      T_OUT:  if (out_ch.ready) tst_d = T_IDLE;
      default: tst_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tst_q <= T_IDLE;
    else         tst_q <= tst_d;
  end

  assign out_ch.valid = (tst_q == T_OUT);
  assign out_ch.data.out_r0c0 = mat_out[0];
  assign out_ch.data.out_r0c1 = mat_out[1];
  assign out_ch.data.out_r0c2 = mat_out[2];
  assign out_ch.data.out_r1c0 = mat_out[3];
  assign out_ch.data.out_r1c1 = mat_out[4];
  assign out_ch.data.out_r1c2 = mat_out[5];
  assign out_ch.data.out_r2c0 = mat_out[6];
  assign out_ch.data.out_r2c1 = mat_out[7];
  assign out_ch.data.out_r2c2 = mat_out[8];
  assign out_ch.data.status   = st;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tst_q != T_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> (tst_q == T_BUSY)) else $error("done outside busy");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (st == ST_OK || st == ST_SINGULAR || st == ST_OVERFLOW))
    else $error("bad status");
endmodule
